@@ rtl/pid_axis_controller_assert.svh @@
// Assertion macros shared by the PID controller RTL.
// Every macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PID_AXIS_CONTROLLER_ASSERT_SVH
`define PID_AXIS_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PID_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PID_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pid_pkg.sv @@
// Shared widths, register indexes and result types for the PID controller.
// No dependencies.
package pid_pkg;

    localparam int DATA_W    = 32;
    localparam int ERR_W     = 33;
    localparam int MUL_A_W   = 49;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
    localparam int MAG_W     = 61;
    localparam int TERM_W    = MAG_W + 1;
    localparam int SUM_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH = 3'd6;

    // Sign-magnitude product from the serial multiplier.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_mul_res;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [TERM_W-1:0] to_signed(input t_mul_res r);
        logic [TERM_W-1:0] m;
        m = {1'b0, r.mag};
        return r.neg ? $signed(~m + 1'b1) : $signed(m);
    endfunction

endpackage

@@ rtl/pid_axis_controller.sv @@
// PID controller top level: configuration registers, controller state and
// the sequencer that drives the serial multiplier and divider.
// Depends on pid_pkg, pid_mul, pid_div and pid_axis_controller_assert.svh.

// One transaction in gives one drive value out, in signed Q16.16. A clear
// request or a zero time step goes straight to the output step. Otherwise
// the item runs three passes through the shared shift-add multiplier plus
// one step for the integrator clamp and one for the output clamp; a first
// sample after a clear or reset needs nothing more. From the second sample
// on, one 49-bit restoring division and a fourth multiplier pass come before
// the output clamp. The output step loads the result only once the output
// register is free, and the block is ready again as soon as it is loaded.
// The next transaction is accepted while the previous result waits at the
// output register.
`include "pid_axis_controller_assert.svh"

module pid_axis_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pid_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pid_pkg::DATA_W-1:0]    i_setpoint,
    input  logic [pid_pkg::DATA_W-1:0]    i_measured,
    input  logic [pid_pkg::DATA_W-1:0]    i_step_time,
    input  logic                          i_clear_state,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pid_pkg::DATA_W-1:0]    o_drive
);
    import pid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_INTEG, S_MULP, S_DIV, S_MULD, S_FIN
    } t_state;

    t_state r_state;

    logic [DATA_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [DATA_W-1:0] r_integ_low, r_integ_high, r_drive_low, r_drive_high;

    logic signed [DATA_W-1:0] r_integ;
    logic [ERR_W-1:0]         r_last_err;
    logic                     r_primed;

    logic [ERR_W-1:0]          r_e;
    logic [ERR_W-1:0]          r_diff_mag;
    logic                      r_diff_neg;
    logic [DATA_W-1:0]         r_dt;
    logic                      r_use_d;
    logic                      r_skip;
    logic                      r_start;
    t_mul_res                  r_t1;
    logic signed [TERM_W-1:0]  r_inc, r_pterm, r_dterm;
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_drive;

    logic [ERR_W-1:0]     e_w;
    logic [ERR_W:0]       diff_w;
    logic [ERR_W-1:0]     e_mag;
    logic                 e_neg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_neg;
    t_mul_res             mul_res;
    logic                 mul_done;
    logic [MUL_A_W-1:0]   div_quo;
    logic                 div_done;

    logic signed [SUM_W-1:0] integ_sum, drive_sum;

    always_comb begin
        e_w    = {i_setpoint[DATA_W-1], i_setpoint} - {i_measured[DATA_W-1], i_measured};
        diff_w = {e_w[ERR_W-1], e_w} - {r_last_err[ERR_W-1], r_last_err};
        e_neg  = r_e[ERR_W-1];
        e_mag  = e_neg ? (~r_e + 1'b1) : r_e;

        mul_a   = {{(MUL_A_W-ERR_W){1'b0}}, e_mag};
        mul_b   = r_dt;
        mul_neg = e_neg;
        case (r_state)
            S_MUL2: begin
                mul_a   = r_t1.mag[MUL_A_W-1:0];
                mul_b   = mag32(r_gain_i);
                mul_neg = r_t1.neg ^ r_gain_i[DATA_W-1];
            end
            S_MULP: begin
                mul_b   = mag32(r_gain_p);
                mul_neg = e_neg ^ r_gain_p[DATA_W-1];
            end
            S_MULD: begin
                mul_a   = div_quo;
                mul_b   = mag32(r_gain_d);
                mul_neg = r_diff_neg ^ r_gain_d[DATA_W-1];
            end
            default: begin
            end
        endcase

        integ_sum = SUM_W'(r_integ) + SUM_W'(r_inc);
        drive_sum = SUM_W'(r_pterm) + SUM_W'(r_integ) + SUM_W'(r_dterm);
    end

    pid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start && r_state != S_DIV),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_neg   (mul_neg),
        .o_res   (mul_res),
        .o_done  (mul_done)
    );

    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start && r_state == S_DIV),
        .i_num   ({r_diff_mag, 16'b0}),
        .i_den   (r_dt),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_integ_low  <= '0;
            r_integ_high <= '0;
            r_drive_low  <= '0;
            r_drive_high <= '0;
            r_integ      <= '0;
            r_last_err   <= '0;
            r_primed     <= 1'b0;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                    REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                    REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                    REG_INTEG_LOW:  r_integ_low  <= i_cfg_data;
                    REG_INTEG_HIGH: r_integ_high <= i_cfg_data;
                    REG_DRIVE_LOW:  r_drive_low  <= i_cfg_data;
                    REG_DRIVE_HIGH: r_drive_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dt <= i_step_time;
                        if (i_clear_state) begin
                            r_integ    <= '0;
                            r_last_err <= '0;
                            r_primed   <= 1'b0;
                            r_skip     <= 1'b1;
                            r_state    <= S_FIN;
                        end else if (i_step_time == '0) begin
                            r_skip  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_skip     <= 1'b0;
                            r_e        <= e_w;
                            r_diff_neg <= diff_w[ERR_W];
                            r_diff_mag <= diff_w[ERR_W] ? ERR_W'(~diff_w + 1'b1)
                                                        : diff_w[ERR_W-1:0];
                            r_last_err <= e_w;
                            r_use_d    <= r_primed;
                            r_primed   <= 1'b1;
                            r_start    <= 1'b1;
                            r_state    <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    if (mul_done) begin
                        r_t1    <= mul_res;
                        r_start <= 1'b1;
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (mul_done) begin
                        r_inc   <= to_signed(mul_res);
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (integ_sum < SUM_W'(r_integ_low)) begin
                        r_integ <= r_integ_low;
                    end else if (integ_sum > SUM_W'(r_integ_high)) begin
                        r_integ <= r_integ_high;
                    end else begin
                        r_integ <= integ_sum[DATA_W-1:0];
                    end
                    r_start <= 1'b1;
                    r_state <= S_MULP;
                end
                S_MULP: begin
                    if (mul_done) begin
                        r_pterm <= to_signed(mul_res);
                        if (r_use_d) begin
                            r_start <= 1'b1;
                            r_state <= S_DIV;
                        end else begin
                            r_dterm <= '0;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_start <= 1'b1;
                        r_state <= S_MULD;
                    end
                end
                S_MULD: begin
                    if (mul_done) begin
                        r_dterm <= to_signed(mul_res);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Wait for the output register to free up before loading it.
                    if (!r_out_valid || i_ready) begin
                        if (r_skip) begin
                            r_drive <= '0;
                        end else if (drive_sum < SUM_W'(r_drive_low)) begin
                            r_drive <= r_drive_low;
                        end else if (drive_sum > SUM_W'(r_drive_high)) begin
                            r_drive <= r_drive_high;
                        end else begin
                            r_drive <= drive_sum[DATA_W-1:0];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    `PID_AST_SAME(a_mul_done_state, mul_done, (r_state == S_MUL1 || r_state == S_MUL2 || r_state == S_MULP || r_state == S_MULD), "multiplier finished outside a multiply step")
    `PID_AST_SAME(a_div_done_state, div_done, r_state == S_DIV, "divider finished outside the divide step")
    `PID_AST_NEXT(a_accept_busy, i_valid && o_ready, r_state != S_IDLE, "accepted transaction did not start work")
    `PID_AST_NEXT(a_div_primed, r_state == S_MULP && mul_done && r_use_d, r_state == S_DIV && r_start, "derivative divide not launched")

endmodule

@@ rtl/pid_mul.sv @@
// Shift-add multiplier: one multiplier bit per cycle, Q16.16 truncation and
// saturation to 2^60 on the magnitude. Depends on pid_pkg.
module pid_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pid_pkg::MUL_A_W-1:0] i_a,
    input  logic [pid_pkg::MUL_B_W-1:0] i_b,
    input  logic                      i_neg,
    output pid_pkg::t_mul_res         o_res,
    output logic                      o_done
);
    import pid_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam int HI_W  = MUL_P_W - MUL_B_W;
    localparam int SH_W  = MUL_P_W - 16;

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_fin;
    logic               r_neg;
    t_mul_res           r_res;
    logic               r_done;

    logic [HI_W:0]      n_hi;
    logic [SH_W-1:0]    shifted;
    logic               sat;

    always_comb begin
        n_hi = {1'b0, r_p[MUL_P_W-1:MUL_B_W]}
             + (r_p[0] ? {{(HI_W+1-MUL_A_W){1'b0}}, r_a} : '0);
        shifted = r_p[MUL_P_W-1:16];
        sat = (|shifted[SH_W-1:MAG_W]) || (shifted[MAG_W-1] && (|shifted[MAG_W-2:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_neg  <= i_neg;
                r_p    <= {{HI_W{1'b0}}, i_b};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= {n_hi, r_p[MUL_B_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin     <= 1'b0;
                r_done    <= 1'b1;
                r_res.neg <= r_neg;
                r_res.mag <= sat ? {1'b1, {(MAG_W-1){1'b0}}} : shifted[MAG_W-1:0];
            end
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;
endmodule

@@ rtl/pid_div.sv @@
// Restoring divider: one quotient bit per cycle, unsigned numerator over a
// nonzero unsigned divisor, quotient truncated. Depends on pid_pkg.
module pid_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pid_pkg::MUL_A_W-1:0] i_num,
    input  logic [pid_pkg::DATA_W-1:0]  i_den,
    output logic [pid_pkg::MUL_A_W-1:0] o_quo,
    output logic                        o_done
);
    import pid_pkg::*;

    localparam int CNT_W = $clog2(MUL_A_W);

    logic [MUL_A_W-1:0] r_q;
    logic [DATA_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DATA_W:0]    trial;
    logic [DATA_W+1:0]  diff;
    logic               ge;

    always_comb begin
        trial = {r_rem, r_q[MUL_A_W-1]};
        diff  = {1'b0, trial} - {2'b0, r_den};
        ge    = !diff[DATA_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                r_q   <= {r_q[MUL_A_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_A_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for pid_axis_controller: directed table, then random transactions.
// Depends on pid_pkg and the controller RTL; the expected drive comes from a local predictor.
`timescale 1ns / 1ps

module tb;
    import pid_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint SAT_MAG = longint'(1) << 60;
    localparam int RANDOM_ITEMS = 1620;

    typedef struct {
        int          phase;
        logic [31:0] sp;
        logic [31:0] me;
        logic [31:0] dt;
        bit          clr;
        bit          fixed;
        logic [31:0] val;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [DATA_W-1:0]    i_setpoint = '0;
    logic [DATA_W-1:0]    i_measured = '0;
    logic [DATA_W-1:0]    i_step_time = '0;
    logic                 i_clear_state = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [DATA_W-1:0]    o_drive;

    // Predictor copy of the registers and controller state.
    longint gain_p_m, gain_i_m, gain_d_m, integ_lo_m, integ_hi_m, drive_lo_m, drive_hi_m;
    longint integ_m, last_err_m;
    bit     primed_m;

    logic [31:0] drive_q[$];
    int          errors = 0;
    bit          hold_req = 1'b0;
    t_row        rows[$];

    pid_axis_controller u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint q_mul(longint a, longint b);
        logic [63:0]  ma, mb;
        logic [127:0] pr;
        longint       r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        pr = ({64'd0, ma} * {64'd0, mb}) >> 16;
        if (pr > 128'(SAT_MAG)) pr = 128'(SAT_MAG);
        r = longint'(pr[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint clamp_lh(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [31:0] pid_predict(logic [31:0] sp, logic [31:0] me,
                                                logic [31:0] dt, bit clr);
        longint      e, diff, deriv, sum;
        logic [63:0] q;
        if (clr) begin
            integ_m = 0;
            last_err_m = 0;
            primed_m = 1'b0;
            return '0;
        end
        if (dt == 0) return '0;
        e = longint'($signed(sp)) - longint'($signed(me));
        integ_m = clamp_lh(integ_m + q_mul(q_mul(e, longint'({32'd0, dt})), gain_i_m),
                           integ_lo_m, integ_hi_m);
        deriv = 0;
        if (primed_m) begin
            diff = e - last_err_m;
            q = (64'((diff < 0) ? -diff : diff) << 16) / {32'd0, dt};
            deriv = (diff < 0) ? -longint'(q) : longint'(q);
        end
        primed_m = 1'b1;
        last_err_m = e;
        sum = q_mul(e, gain_p_m) + integ_m + q_mul(deriv, gain_d_m);
        return 32'(clamp_lh(sum, drive_lo_m, drive_hi_m));
    endfunction

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        longint v;
        v = longint'($signed(data));
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_GAIN_P:     gain_p_m = v;
            REG_GAIN_I:     gain_i_m = v;
            REG_GAIN_D:     gain_d_m = v;
            REG_INTEG_LOW:  integ_lo_m = v;
            REG_INTEG_HIGH: integ_hi_m = v;
            REG_DRIVE_LOW:  drive_lo_m = v;
            REG_DRIVE_HIGH: drive_hi_m = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_gain();
        if ($urandom_range(9) < 7) return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        return $urandom;
    endfunction

    task automatic cfg_apply(int set);
        logic [31:0] a, b;
        wait_drained();
        case (set)
            1: begin
                cfg_write(REG_GAIN_P, 32'h0001_0000);
                cfg_write(REG_GAIN_I, 32'h0000_8000);
                cfg_write(REG_GAIN_D, 32'h0000_4000);
                cfg_write(REG_INTEG_LOW, 32'hFF9C_0000);
                cfg_write(REG_INTEG_HIGH, 32'h0064_0000);
                cfg_write(REG_DRIVE_LOW, 32'hFC18_0000);
                cfg_write(REG_DRIVE_HIGH, 32'h03E8_0000);
            end
            2: begin
                cfg_write(REG_GAIN_P, 32'h7FFF_FFFF);
                cfg_write(REG_GAIN_I, 32'h8000_0000);
                cfg_write(REG_GAIN_D, 32'h7FFF_FFFF);
                cfg_write(REG_INTEG_LOW, 32'h8000_0000);
                cfg_write(REG_INTEG_HIGH, 32'h7FFF_FFFF);
                cfg_write(REG_DRIVE_LOW, 32'h8000_0000);
                cfg_write(REG_DRIVE_HIGH, 32'h7FFF_FFFF);
            end
            3: begin
                // Inverted bounds: anything not below the low bound lands on the high one.
                cfg_write(REG_GAIN_P, 32'h8000_0000);
                cfg_write(REG_GAIN_I, 32'h0002_0000);
                cfg_write(REG_GAIN_D, 32'h8000_0000);
                cfg_write(REG_INTEG_LOW, 32'h0001_0000);
                cfg_write(REG_INTEG_HIGH, 32'hFFFF_0000);
                cfg_write(REG_DRIVE_LOW, 32'h0010_0000);
                cfg_write(REG_DRIVE_HIGH, 32'hFFF0_0000);
            end
            default: begin
                cfg_write(REG_GAIN_P, rnd_gain());
                cfg_write(REG_GAIN_I, rnd_gain());
                cfg_write(REG_GAIN_D, rnd_gain());
                a = $urandom;
                b = $urandom;
                if ($urandom_range(9) < 8) begin
                    a = 32'($signed($urandom_range(32'h0100_0000)) * -1);
                    b = $urandom_range(32'h0100_0000);
                end
                cfg_write(REG_INTEG_LOW, a);
                cfg_write(REG_INTEG_HIGH, b);
                a = $urandom;
                b = $urandom;
                if ($urandom_range(9) < 8) begin
                    a = 32'h8000_0000 | $urandom_range(32'h00FF_FFFF);
                    b = 32'h7FFF_FFFF - $urandom_range(32'h00FF_FFFF);
                end
                cfg_write(REG_DRIVE_LOW, a);
                cfg_write(REG_DRIVE_HIGH, b);
            end
        endcase
        cfg_write(REG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int rnd_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Called at the edge where the previous transaction was taken (or at an idle edge).
    task automatic send(logic [31:0] sp, logic [31:0] me, logic [31:0] dt, bit clr,
                        bit fixed, logic [31:0] val);
        int          gap;
        logic [31:0] exp_drive;
        gap = rnd_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= me;
        i_step_time <= dt;
        i_clear_state <= clr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exp_drive = pid_predict(sp, me, dt, clr);
        drive_q.push_back(fixed ? val : exp_drive);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (drive_q.size() == 0) begin
                $display("%0t: drive %h with no transaction pending", $time, o_drive);
                errors++;
            end else begin
                if (o_drive !== drive_q[0]) begin
                    $display("%0t: drive expected %h actual %h", $time, drive_q[0], o_drive);
                    errors++;
                end
                void'(drive_q.pop_front());
            end
        end
    end

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (600) @(posedge i_clk);
            end else begin
                n = $urandom_range(99);
                if (n < 60) i_ready <= 1'b1;
                else if (n < 97) i_ready <= 1'b0;
                else begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #30ms;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int          cur;
        logic [31:0] sp, me, dt;
        bit          clr;
        gain_p_m = 0; gain_i_m = 0; gain_d_m = 0;
        integ_lo_m = 0; integ_hi_m = 0; drive_lo_m = 0; drive_hi_m = 0;
        integ_m = 0; last_err_m = 0; primed_m = 1'b0;

        // Phase 0 runs on reset registers, so every drive comes out zero.
        rows.push_back('{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 0});
        rows.push_back('{0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 1, 0});
        rows.push_back('{0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 0, 1, 0});
        rows.push_back('{0, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1, 1, 0});
        rows.push_back('{1, 32'h0005_0000, 32'h0001_0000, 32'h0000_199A, 0, 0, 0});
        rows.push_back('{1, 32'h0005_0000, 32'h0002_0000, 32'h0000_199A, 0, 0, 0});
        rows.push_back('{1, 32'h0005_0000, 32'h0002_0000, 32'h0000_0000, 0, 1, 0});
        rows.push_back('{1, 32'hFFFB_0000, 32'h0003_0000, 32'h0000_199A, 0, 0, 0});
        rows.push_back('{1, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1, 1, 0});
        rows.push_back('{1, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 0, 0, 0});
        rows.push_back('{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0, 0, 0});
        rows.push_back('{1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0});
        rows.push_back('{1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0, 0});
        rows.push_back('{2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0});
        rows.push_back('{2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0, 0});
        rows.push_back('{2, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 0, 0, 0});
        rows.push_back('{2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 1, 0});
        rows.push_back('{2, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_8000, 0, 0, 0});
        rows.push_back('{3, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 0, 0, 0});
        rows.push_back('{3, 32'hFFF0_0000, 32'h0010_0000, 32'h0001_0000, 0, 0, 0});
        rows.push_back('{3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 1, 0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur = 0;
        foreach (rows[k]) begin
            if (rows[k].phase != cur) begin
                i_valid <= 1'b0;
                cur = rows[k].phase;
                cfg_apply(cur);
            end
            send(rows[k].sp, rows[k].me, rows[k].dt, rows[k].clr, rows[k].fixed, rows[k].val);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 200 == 0) begin
                i_valid <= 1'b0;
                cfg_apply(4);
            end
            if (k == 30) hold_req = 1'b1;
            if ($urandom_range(99) == 0 || k == 120) begin
                i_valid <= 1'b0;
                wait_drained();
            end
            clr = ($urandom_range(99) < 3);
            if ($urandom_range(99) < 85) begin
                // Plausible control samples keep the integrator and derivative in play.
                sp = 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
                me = 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
                dt = $urandom_range(32'h100, 32'h2_0000);
            end else begin
                sp = $urandom;
                me = $urandom;
                dt = $urandom;
            end
            if ($urandom_range(99) < 3) dt = '0;
            send(sp, me, dt, clr, 0, 0);
        end
        i_valid <= 1'b0;

        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
